FILE: src/free_space_goal_check_macros.svh
// Assertion macros shared by the free-space goal check checker
`ifndef FREE_SPACE_GOAL_CHECK_MACROS_SVH
`define FREE_SPACE_GOAL_CHECK_MACROS_SVH

// checked only outside reset
`define FSGC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FSGC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fsgc_pkg.sv
// Types and constants of the free-space goal check
package fsgc_pkg;

    localparam int MAP_SIDE    = 512;
    localparam int MAP_AW      = $clog2(MAP_SIDE);
    localparam int MAP_DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W      = 2 * MAP_AW;
    localparam int REGION_SIZE = 10;
    localparam int WINDOW_HALF = 5;
    localparam int WIN_SIDE    = 2 * WINDOW_HALF + 1;
    localparam int WIN_W       = $clog2(WIN_SIDE);

    localparam int PIX_W   = 9;
    localparam int VAL_W   = 8;
    localparam int BLK_W   = 6;
    localparam int DIM_W   = 10;
    localparam int ORG_W   = 9;
    localparam int OFF_W   = 10;
    localparam int OFF_MAX = 511;

    // largest centre plus the window half must fit
    localparam int COORD_W = $clog2(((1 << BLK_W) - 1) * REGION_SIZE + REGION_SIZE / 2
                                    + WINDOW_HALF + 1);
    localparam int POS_W   = COORD_W + 1;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int CMP_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_CHECK = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_ORIGIN_COL = 2'd2,
        CFG_ORIGIN_ROW = 2'd3
    } t_cfg_idx;

    localparam logic [DIM_W-1:0] RST_MAP_WIDTH  = DIM_W'(512);
    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = DIM_W'(512);
    localparam logic [ORG_W-1:0] RST_ORIGIN_COL = ORG_W'(256);
    localparam logic [ORG_W-1:0] RST_ORIGIN_ROW = ORG_W'(256);

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic              wdata;
    } t_map_req;

endpackage

FILE: src/fsgc_if.sv
// Handshake channel interfaces of the free-space goal check
interface fsgc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [fsgc_pkg::PIX_W-1:0]     pixel_row;
    logic [fsgc_pkg::PIX_W-1:0]     pixel_col;
    logic [fsgc_pkg::VAL_W-1:0]     pixel_value;
    logic [fsgc_pkg::BLK_W-1:0]     block_row;
    logic [fsgc_pkg::BLK_W-1:0]     block_col;

    modport source (output valid, command, pixel_row, pixel_col, pixel_value,
                    block_row, block_col, input ready);
    modport sink   (input valid, command, pixel_row, pixel_col, pixel_value,
                    block_row, block_col, output ready);
endinterface

interface fsgc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               goal_valid;
    logic signed [fsgc_pkg::OFF_W-1:0]  goal_row_offset;
    logic signed [fsgc_pkg::OFF_W-1:0]  goal_col_offset;

    modport source (output valid, goal_valid, goal_row_offset, goal_col_offset,
                    input ready);
    modport sink   (input valid, goal_valid, goal_row_offset, goal_col_offset,
                    output ready);
endinterface

interface fsgc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fsgc_pkg::CFG_IDX_W-1:0]     index;
    logic [fsgc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/fsgc_bitmap.sv
// Single-port free-bit map memory with registered read
module fsgc_bitmap (
    input  logic               i_clk,
    input  fsgc_pkg::t_map_req i_req,
    output logic               o_rd_data
);
    import fsgc_pkg::*;

    logic r_mem [MAP_DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/free_space_goal_check.sv
// Top level of the free-space goal check
// Use:
//   i_in carries one word per command. A write word (command 0) stores one map
//   pixel as free when pixel_value is zero, and writes may follow each other on
//   every cycle while the block is idle. A check word (command 1) names a region
//   by block_row / block_col; the block walks the 11 x 11 window round the
//   region centre through the single port of the bit map, one pixel a cycle.
//   A check holds i_in.ready low through the window reads, a drain state for
//   the last read data and a finish state that loads the result register.
//   o_res gives one word per check: goal_valid and the centre's offsets from
//   the origin, saturated to -511..511. The result register lets the next
//   word be taken while a result waits; a stalled receiver only delays the
//   end of the following check.
//   i_cfg, always ready, writes map_width, map_height, origin_col and origin_row
//   by index; the user writes it only while the block is idle, unenforced.
//   Reset restores the register defaults and empties the result register;
//   map contents are undefined until written.
module free_space_goal_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsgc_in_if.sink     i_in,
    fsgc_cfg_if.sink    i_cfg,
    fsgc_out_if.source  o_res
);
    import fsgc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    function automatic logic signed [OFF_W-1:0] sat_off(
        input logic [COORD_W-1:0] centre,
        input logic [ORG_W-1:0]   origin
    );
        logic signed [DIFF_W-1:0] d;
        d = $signed(DIFF_W'(centre)) - $signed(DIFF_W'(origin));
        if (d > $signed(DIFF_W'(OFF_MAX))) begin
            return OFF_W'(OFF_MAX);
        end else if (d < -$signed(DIFF_W'(OFF_MAX))) begin
            return -OFF_W'(OFF_MAX);
        end else begin
            return d[OFF_W-1:0];
        end
    endfunction

    t_state                   r_state;
    logic [DIM_W-1:0]         r_map_width;
    logic [DIM_W-1:0]         r_map_height;
    logic [ORG_W-1:0]         r_origin_col;
    logic [ORG_W-1:0]         r_origin_row;
    logic [COORD_W-1:0]       r_crow;
    logic [COORD_W-1:0]       r_ccol;
    logic [WIN_W-1:0]         r_dr;
    logic [WIN_W-1:0]         r_dc;
    logic                     r_pend;
    logic                     r_pend_in;
    logic                     r_ok;
    logic                     r_out_valid;
    logic                     r_goal_valid;
    logic signed [OFF_W-1:0]  r_row_off;
    logic signed [OFF_W-1:0]  r_col_off;

    logic                     in_acc;
    logic                     rd_data;
    logic [POS_W-1:0]         pos_row;
    logic [POS_W-1:0]         pos_col;
    logic                     row_in;
    logic                     col_in;
    logic [COORD_W-1:0]       new_crow;
    logic [COORD_W-1:0]       new_ccol;
    t_map_req                 map_req;

    assign in_acc = i_in.valid && i_in.ready;

    assign new_crow = COORD_W'(i_in.block_row) * COORD_W'(REGION_SIZE)
                    + COORD_W'(REGION_SIZE / 2);
    assign new_ccol = COORD_W'(i_in.block_col) * COORD_W'(REGION_SIZE)
                    + COORD_W'(REGION_SIZE / 2);

    // window position, negative when it falls above or left of the map
    assign pos_row = POS_W'(r_crow) + POS_W'(r_dr) - POS_W'(WINDOW_HALF);
    assign pos_col = POS_W'(r_ccol) + POS_W'(r_dc) - POS_W'(WINDOW_HALF);

    assign row_in = !pos_row[POS_W-1]
                 && (CMP_W'(pos_row) < CMP_W'(r_map_height))
                 && (CMP_W'(pos_row) < CMP_W'(MAP_SIDE));
    assign col_in = !pos_col[POS_W-1]
                 && (CMP_W'(pos_col) < CMP_W'(r_map_width))
                 && (CMP_W'(pos_col) < CMP_W'(MAP_SIDE));

    always_comb begin
        map_req.we    = in_acc && (i_in.command == CMD_WRITE);
        map_req.re    = (r_state == ST_SCAN);
        map_req.wdata = (i_in.pixel_value == '0);
        if (r_state == ST_SCAN) begin
            map_req.addr = {pos_row[MAP_AW-1:0], pos_col[MAP_AW-1:0]};
        end else begin
            map_req.addr = {i_in.pixel_row[MAP_AW-1:0], i_in.pixel_col[MAP_AW-1:0]};
        end
    end

    fsgc_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_req     (map_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= RST_MAP_WIDTH;
            r_map_height <= RST_MAP_HEIGHT;
            r_origin_col <= RST_ORIGIN_COL;
            r_origin_row <= RST_ORIGIN_ROW;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MAP_WIDTH:  r_map_width  <= DIM_W'(i_cfg.data);
                CFG_MAP_HEIGHT: r_map_height <= DIM_W'(i_cfg.data);
                CFG_ORIGIN_COL: r_origin_col <= ORG_W'(i_cfg.data);
                CFG_ORIGIN_ROW: r_origin_row <= ORG_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_SCAN);
            if (r_pend) begin
                r_ok <= r_ok && r_pend_in && rd_data;
            end
            if ((r_state == ST_FINISH) && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.command == CMD_CHECK)) begin
                        r_crow  <= new_crow;
                        r_ccol  <= new_ccol;
                        r_dr    <= '0;
                        r_dc    <= '0;
                        r_ok    <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pend_in <= row_in && col_in;
                    if (r_dc == WIN_W'(WIN_SIDE - 1)) begin
                        r_dc <= '0;
                        if (r_dr == WIN_W'(WIN_SIDE - 1)) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_dr <= r_dr + 1'b1;
                        end
                    end else begin
                        r_dc <= r_dc + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_goal_valid <= r_ok;
                        r_row_off    <= sat_off(r_crow, r_origin_row);
                        r_col_off    <= sat_off(r_ccol, r_origin_col);
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready            = (r_state == ST_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_res.valid           = r_out_valid;
    assign o_res.goal_valid      = r_goal_valid;
    assign o_res.goal_row_offset = r_row_off;
    assign o_res.goal_col_offset = r_col_off;

endmodule

FILE: src/fsgc_checker.sv
// Port-level assertions of the free-space goal check, bound to the top level
`include "free_space_goal_check_macros.svh"

module fsgc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_command,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_goal_valid,
    input logic [fsgc_pkg::OFF_W-1:0]    i_goal_row_offset,
    input logic [fsgc_pkg::OFF_W-1:0]    i_goal_col_offset
);
    import fsgc_pkg::*;

    `FSGC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")
    `FSGC_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_goal_valid) && $stable(i_goal_row_offset) && $stable(i_goal_col_offset), "stalled word changed")
    `FSGC_ASSERT(a_write_no_result, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_WRITE) && !i_out_valid |=> !i_out_valid, "result from a write")
    `FSGC_ASSERT(a_check_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_CHECK) |=> !i_in_ready, "ready during check")
    `FSGC_ASSERT(a_offset_sat, i_clk, i_rst_n, i_out_valid |-> !(i_goal_row_offset[OFF_W-1] && (i_goal_row_offset[OFF_W-2:0] == '0)) && !(i_goal_col_offset[OFF_W-1] && (i_goal_col_offset[OFF_W-2:0] == '0)), "offset beyond saturation")

endmodule

bind free_space_goal_check fsgc_checker u_fsgc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_command      (i_in.command),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_goal_valid      (o_res.goal_valid),
    .i_goal_row_offset (o_res.goal_row_offset),
    .i_goal_col_offset (o_res.goal_col_offset)
);
